/* sv/pdpf_pkg.sv */
// Shared constants, types and helpers for the PD path follower.
package pdpf_pkg;

   localparam int PATH_DEPTH_DEFAULT = 256;
   localparam int COORD_W            = 32;
   localparam int GAIN_W             = 31;
   localparam int TRIG_W             = 18;
   localparam int CSR_IDX_W          = 3;
   localparam int REQ_DATA_W         = 200;
   localparam int RSP_DATA_W         = 128;
   localparam int DIV_NUM_W          = 49;
   localparam int DIV_DEN_W          = 31;

   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_APPEND = 2'd1,
      OP_TICK   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROP_GAIN   = 3'd0,
      CSR_DERIV_GAIN  = 3'd1,
      CSR_LOOKAHEAD   = 3'd2,
      CSR_MAX_LINEAR  = 3'd3,
      CSR_MAX_TURN    = 3'd4,
      CSR_GOAL_TOL    = 3'd5,
      CSR_SPARE6      = 3'd6,
      CSR_SPARE7      = 3'd7
   } csr_idx_type;

   typedef enum logic [13:0] {
      ST_IDLE      = 14'b00000000000001,
      ST_LIM_LOAD  = 14'b00000000000010,
      ST_LIM_SQ    = 14'b00000000000100,
      ST_LIM_SAVE  = 14'b00000000001000,
      ST_SCAN      = 14'b00000000010000,
      ST_GOAL_RD   = 14'b00000000100000,
      ST_GOAL_WAIT = 14'b00000001000000,
      ST_ROTATE    = 14'b00000010000000,
      ST_ERRS      = 14'b00000100000000,
      ST_DSTART    = 14'b00001000000000,
      ST_DWAIT     = 14'b00010000000000,
      ST_PDMUL     = 14'b00100000000000,
      ST_PDSUM     = 14'b01000000000000,
      ST_FINISH    = 14'b10000000000000
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_NUM_W-1:0] quo;
   } div_rsp_type;

   localparam logic [GAIN_W-1:0] RST_PROP_GAIN  = 31'd131072;
   localparam logic [GAIN_W-1:0] RST_DERIV_GAIN = 31'd6554;
   localparam logic [GAIN_W-1:0] RST_LOOKAHEAD  = 31'd13107;
   localparam logic [GAIN_W-1:0] RST_MAX_LINEAR = 31'd19661;
   localparam logic [GAIN_W-1:0] RST_MAX_TURN   = 31'd65536;
   localparam logic [GAIN_W-1:0] RST_GOAL_TOL   = 31'd3932;

   localparam logic signed [COORD_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] S32_MIN = 32'sh8000_0000;

endpackage

/* sv/pd_path_follower_unit.sv */
// Top level of the PD path follower: path loading, target scan and PD control.
//
// Items arrive on the req_ stream. Operation start or append writes one path
// point into the path memory and gives no result. A control tick on a
// non-empty path gives one result on the rsp_ stream.
// A tick streams the path through the distance pipeline from the last point
// downwards, one point per cycle, stopping at the first point inside the
// lookahead distance. The chosen point is read again and checked against the
// goal tolerance. Otherwise the offset is rotated into the robot frame and
// each axis goes through a bit-serial divider and the PD law. The divider is
// skipped when the elapsed time is zero, and the rotation, divider and PD law
// are all skipped when the goal is reached.
// Configuration registers are to be written on the csr_ port only while the
// block idles; the block itself does not enforce this.
// Reset empties the path, clears both stored errors and reloads the default
// register values; no memory clearing pass is needed.
// A result waits in the rsp_ output register until it is taken; the block
// accepts the next item meanwhile and holds a new result until the slot frees.
module pd_path_follower_unit #(
   parameter int PATH_DEPTH = pdpf_pkg::PATH_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // point_x, point_y, robot_x, robot_y, heading_cos, heading_sin, elapsed_time
   input  logic [pdpf_pkg::REQ_DATA_W-1:0]     req_tdata,
   // operation
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // linear_command, angular_command, target_x, target_y
   output logic [pdpf_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // status
   output logic                                rsp_tuser,
   input  logic                                csr_we,
   input  logic [pdpf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pdpf_pkg::GAIN_W-1:0]         csr_wdata
);

   localparam int AW = $clog2(PATH_DEPTH);
   localparam int LW = $clog2(PATH_DEPTH + 1);

   pdpf_pkg::state_type state_ff, state_in;

   logic [30:0] prop_gain_ff, deriv_gain_ff, lookahead_ff;
   logic [30:0] max_lin_ff, max_turn_ff, goal_tol_ff;

   logic [LW-1:0] path_len_ff;
   logic signed [31:0] last_a_ff, last_c_ff;

   logic signed [31:0] rx_ff, ry_ff;
   logic signed [17:0] hc_ff, hs_ff;
   logic [30:0]        dt_ff;

   logic          mem_wr_en, mem_rd_en;
   logic [AW-1:0] mem_wr_addr, mem_rd_addr;
   logic [63:0]   mem_rd_data;

   logic [AW-1:0] scan_idx_ff;
   logic          issue_on_ff;
   logic [AW-1:0] sel_idx_ff;

   logic          rd_vld_ff;
   logic [AW-1:0] rd_idx_ff;
   logic          a_vld_ff, b_vld_ff;
   logic [AW-1:0] a_idx_ff, b_idx_ff;
   logic signed [31:0] a_px_ff, a_py_ff, b_px_ff, b_py_ff;
   logic signed [32:0] a_dx_ff, a_dy_ff, b_dx_ff, b_dy_ff;
   logic [31:0]   ax_ff, ay_ff;
   logic [63:0]   sqx_ff, sqy_ff;
   logic [63:0]   lim_look_ff, lim_goal_ff;
   logic [64:0]   sq_sum;
   logic          pipe_hit, scan_hit, pipe_kill;

   logic signed [32:0] q_dx, q_dy;
   logic signed [31:0] q_px, q_py;

   logic signed [31:0] t_px_ff, t_py_ff;
   logic signed [32:0] t_dx_ff, t_dy_ff;
   logic signed [50:0] pcx_ff, psy_ff, pcy_ff, psx_ff;
   logic signed [51:0] along_sum, across_sum;
   logic signed [31:0] err_a_ff, err_c_ff;

   logic               axis_ff;
   logic signed [31:0] e_cur, e_last;
   logic [30:0]        e_lim;
   logic signed [32:0] diff;
   logic [32:0]        diff_mag;
   logic               dneg_ff;
   logic signed [31:0] deriv_ff;
   logic signed [63:0] pp_ff, pq_ff;
   logic signed [48:0] u_sum;
   logic signed [31:0] u_clamp;

   logic               res_status_ff;
   logic signed [31:0] res_lin_ff, res_ang_ff;

   logic               rsp_tvalid_ff;
   logic [pdpf_pkg::RSP_DATA_W-1:0] rsp_tdata_ff;
   logic               rsp_tuser_ff;

   pdpf_pkg::div_req_type div_req;
   pdpf_pkg::div_rsp_type div_rsp;

   logic req_fire;
   pdpf_pkg::op_type req_op;

   function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
      if (v > 36'sh0_7FFF_FFFF) begin
         return pdpf_pkg::S32_MAX;
      end else if (v < -36'sh0_8000_0000) begin
         return pdpf_pkg::S32_MIN;
      end
      return v[31:0];
   endfunction

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == pdpf_pkg::ST_IDLE);
   assign req_op     = pdpf_pkg::op_type'(req_tuser);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= pdpf_pkg::RST_PROP_GAIN;
         deriv_gain_ff <= pdpf_pkg::RST_DERIV_GAIN;
         lookahead_ff  <= pdpf_pkg::RST_LOOKAHEAD;
         max_lin_ff    <= pdpf_pkg::RST_MAX_LINEAR;
         max_turn_ff   <= pdpf_pkg::RST_MAX_TURN;
         goal_tol_ff   <= pdpf_pkg::RST_GOAL_TOL;
      end else if (csr_we) begin
         case (pdpf_pkg::csr_idx_type'(csr_index))
            pdpf_pkg::CSR_PROP_GAIN:  prop_gain_ff  <= csr_wdata;
            pdpf_pkg::CSR_DERIV_GAIN: deriv_gain_ff <= csr_wdata;
            pdpf_pkg::CSR_LOOKAHEAD:  lookahead_ff  <= csr_wdata;
            pdpf_pkg::CSR_MAX_LINEAR: max_lin_ff    <= csr_wdata;
            pdpf_pkg::CSR_MAX_TURN:   max_turn_ff   <= csr_wdata;
            pdpf_pkg::CSR_GOAL_TOL:   goal_tol_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Path memory.
   assign mem_wr_en   = req_fire && ((req_op == pdpf_pkg::OP_START) ||
                        ((req_op == pdpf_pkg::OP_APPEND) && (path_len_ff < LW'(PATH_DEPTH))));
   assign mem_wr_addr = (req_op == pdpf_pkg::OP_START) ? '0 : path_len_ff[AW-1:0];
   assign mem_rd_en   = ((state_ff == pdpf_pkg::ST_SCAN) && issue_on_ff) ||
                        (state_ff == pdpf_pkg::ST_GOAL_RD);
   assign mem_rd_addr = (state_ff == pdpf_pkg::ST_GOAL_RD) ? sel_idx_ff : scan_idx_ff;

   pdpf_path_mem #(
      .DEPTH(PATH_DEPTH)
   ) u_mem (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(req_tdata[63:0]),
      .rd_en  (mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   // Distance pipeline: read, offset and magnitude, squares, compare.
   assign q_px = mem_rd_data[31:0];
   assign q_py = mem_rd_data[63:32];
   assign q_dx = {q_px[31], q_px} - {rx_ff[31], rx_ff};
   assign q_dy = {q_py[31], q_py} - {ry_ff[31], ry_ff};

   assign sq_sum    = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign pipe_hit  = !sq_sum[64] && (sq_sum[63:0] <=
                      ((state_ff == pdpf_pkg::ST_GOAL_WAIT) ? lim_goal_ff : lim_look_ff));
   assign scan_hit  = (state_ff == pdpf_pkg::ST_SCAN) && b_vld_ff && pipe_hit;
   assign pipe_kill = scan_hit;

   always_ff @(posedge clock) begin
      rd_idx_ff <= mem_rd_addr;
      a_idx_ff  <= rd_idx_ff;
      a_px_ff   <= q_px;
      a_py_ff   <= q_py;
      a_dx_ff   <= q_dx;
      a_dy_ff   <= q_dy;
      if (state_ff == pdpf_pkg::ST_LIM_LOAD) begin
         ax_ff <= {1'b0, lookahead_ff};
         ay_ff <= {1'b0, goal_tol_ff};
      end else begin
         ax_ff <= q_dx[32] ? 32'(-q_dx) : q_dx[31:0];
         ay_ff <= q_dy[32] ? 32'(-q_dy) : q_dy[31:0];
      end
      sqx_ff   <= ax_ff * ax_ff;
      sqy_ff   <= ay_ff * ay_ff;
      b_idx_ff <= a_idx_ff;
      b_px_ff  <= a_px_ff;
      b_py_ff  <= a_py_ff;
      b_dx_ff  <= a_dx_ff;
      b_dy_ff  <= a_dy_ff;
      if (reset) begin
         rd_vld_ff <= 1'b0;
         a_vld_ff  <= 1'b0;
         b_vld_ff  <= 1'b0;
      end else begin
         rd_vld_ff <= mem_rd_en && !pipe_kill;
         a_vld_ff  <= rd_vld_ff && !pipe_kill;
         b_vld_ff  <= a_vld_ff && !pipe_kill;
      end
   end

   // Control-law arithmetic.
   assign along_sum  = 52'(pcx_ff) + 52'(psy_ff);
   assign across_sum = 52'(pcy_ff) - 52'(psx_ff);

   assign e_cur    = axis_ff ? err_c_ff : err_a_ff;
   assign e_last   = axis_ff ? last_c_ff : last_a_ff;
   assign e_lim    = axis_ff ? max_turn_ff : max_lin_ff;
   assign diff     = 33'(e_cur) - 33'(e_last);
   assign diff_mag = diff[32] ? 33'(-diff) : diff;

   assign div_req.start = (state_ff == pdpf_pkg::ST_DSTART) && (dt_ff != '0);
   assign div_req.num   = {diff_mag, 16'd0};
   assign div_req.den   = dt_ff;

   pdpf_divider u_div (
      .clock(clock),
      .reset(reset),
      .req  (div_req),
      .rsp  (div_rsp)
   );

   assign u_sum = 49'(pp_ff >>> 16) + 49'(pq_ff >>> 16);
   always_comb begin
      if (u_sum > $signed({18'd0, e_lim})) begin
         u_clamp = $signed({1'b0, e_lim});
      end else if (u_sum < -$signed({18'd0, e_lim})) begin
         u_clamp = -$signed({1'b0, e_lim});
      end else begin
         u_clamp = u_sum[31:0];
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pdpf_pkg::ST_IDLE: begin
            if (req_fire && (req_op == pdpf_pkg::OP_TICK) && (path_len_ff != '0)) begin
               state_in = pdpf_pkg::ST_LIM_LOAD;
            end
         end
         pdpf_pkg::ST_LIM_LOAD: state_in = pdpf_pkg::ST_LIM_SQ;
         pdpf_pkg::ST_LIM_SQ:   state_in = pdpf_pkg::ST_LIM_SAVE;
         pdpf_pkg::ST_LIM_SAVE: state_in = pdpf_pkg::ST_SCAN;
         pdpf_pkg::ST_SCAN: begin
            if (scan_hit || (!issue_on_ff && !rd_vld_ff && !a_vld_ff && !b_vld_ff)) begin
               state_in = pdpf_pkg::ST_GOAL_RD;
            end
         end
         pdpf_pkg::ST_GOAL_RD: state_in = pdpf_pkg::ST_GOAL_WAIT;
         pdpf_pkg::ST_GOAL_WAIT: begin
            if (b_vld_ff) begin
               state_in = pipe_hit ? pdpf_pkg::ST_FINISH : pdpf_pkg::ST_ROTATE;
            end
         end
         pdpf_pkg::ST_ROTATE: state_in = pdpf_pkg::ST_ERRS;
         pdpf_pkg::ST_ERRS:   state_in = pdpf_pkg::ST_DSTART;
         pdpf_pkg::ST_DSTART: begin
            state_in = (dt_ff == '0) ? pdpf_pkg::ST_PDMUL : pdpf_pkg::ST_DWAIT;
         end
         pdpf_pkg::ST_DWAIT: begin
            if (div_rsp.done) begin
               state_in = pdpf_pkg::ST_PDMUL;
            end
         end
         pdpf_pkg::ST_PDMUL: state_in = pdpf_pkg::ST_PDSUM;
         pdpf_pkg::ST_PDSUM: begin
            state_in = axis_ff ? pdpf_pkg::ST_FINISH : pdpf_pkg::ST_DSTART;
         end
         pdpf_pkg::ST_FINISH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               state_in = pdpf_pkg::ST_IDLE;
            end
         end
         default: state_in = pdpf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pdpf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Tick inputs.
   always_ff @(posedge clock) begin
      if (req_fire && (req_op == pdpf_pkg::OP_TICK)) begin
         rx_ff <= req_tdata[95:64];
         ry_ff <= req_tdata[127:96];
         hc_ff <= req_tdata[145:128];
         hs_ff <= req_tdata[163:146];
         dt_ff <= req_tdata[194:164];
      end
   end

   // Path length, scan counter and stored errors.
   always_ff @(posedge clock) begin
      if (reset) begin
         path_len_ff <= '0;
         last_a_ff   <= '0;
         last_c_ff   <= '0;
         issue_on_ff <= 1'b0;
      end else begin
         if (req_fire && (req_op == pdpf_pkg::OP_START)) begin
            path_len_ff <= LW'(1);
         end else if (req_fire && (req_op == pdpf_pkg::OP_APPEND) &&
                      (path_len_ff < LW'(PATH_DEPTH))) begin
            path_len_ff <= path_len_ff + LW'(1);
         end else if ((state_ff == pdpf_pkg::ST_GOAL_WAIT) && b_vld_ff && pipe_hit) begin
            path_len_ff <= '0;
         end
         if ((state_ff == pdpf_pkg::ST_PDSUM) && axis_ff) begin
            last_a_ff <= err_a_ff;
            last_c_ff <= err_c_ff;
         end
         if (state_ff == pdpf_pkg::ST_LIM_SAVE) begin
            issue_on_ff <= 1'b1;
         end else if ((state_ff == pdpf_pkg::ST_SCAN) &&
                      (scan_hit || (scan_idx_ff == '0))) begin
            issue_on_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == pdpf_pkg::ST_LIM_SAVE) begin
         lim_look_ff <= sqx_ff;
         lim_goal_ff <= sqy_ff;
         scan_idx_ff <= AW'(path_len_ff - LW'(1));
      end else if ((state_ff == pdpf_pkg::ST_SCAN) && issue_on_ff) begin
         scan_idx_ff <= scan_idx_ff - AW'(1);
      end
      if (state_ff == pdpf_pkg::ST_SCAN) begin
         sel_idx_ff <= scan_hit ? b_idx_ff : '0;
      end
      if ((state_ff == pdpf_pkg::ST_GOAL_WAIT) && b_vld_ff) begin
         t_px_ff       <= b_px_ff;
         t_py_ff       <= b_py_ff;
         t_dx_ff       <= b_dx_ff;
         t_dy_ff       <= b_dy_ff;
         res_status_ff <= pipe_hit;
         res_lin_ff    <= '0;
         res_ang_ff    <= '0;
      end
      if (state_ff == pdpf_pkg::ST_ROTATE) begin
         pcx_ff <= hc_ff * t_dx_ff;
         psy_ff <= hs_ff * t_dy_ff;
         pcy_ff <= hc_ff * t_dy_ff;
         psx_ff <= hs_ff * t_dx_ff;
      end
      if (state_ff == pdpf_pkg::ST_ERRS) begin
         err_a_ff <= sat36(along_sum[51:16]);
         err_c_ff <= sat36(across_sum[51:16]);
         axis_ff  <= 1'b0;
      end
      if (state_ff == pdpf_pkg::ST_DSTART) begin
         dneg_ff <= diff[32];
         if (diff[32]) begin
            deriv_ff <= pdpf_pkg::S32_MIN;
         end else if (diff != '0) begin
            deriv_ff <= pdpf_pkg::S32_MAX;
         end else begin
            deriv_ff <= '0;
         end
      end
      if ((state_ff == pdpf_pkg::ST_DWAIT) && div_rsp.done) begin
         if (dneg_ff) begin
            deriv_ff <= (div_rsp.quo > 49'h0_8000_0000) ? pdpf_pkg::S32_MIN :
                        32'(-div_rsp.quo);
         end else begin
            deriv_ff <= (div_rsp.quo > 49'h0_7FFF_FFFF) ? pdpf_pkg::S32_MAX :
                        div_rsp.quo[31:0];
         end
      end
      if (state_ff == pdpf_pkg::ST_PDMUL) begin
         pp_ff <= $signed({1'b0, prop_gain_ff}) * e_cur;
         pq_ff <= $signed({1'b0, deriv_gain_ff}) * deriv_ff;
      end
      if (state_ff == pdpf_pkg::ST_PDSUM) begin
         axis_ff <= 1'b1;
         if (axis_ff) begin
            res_ang_ff <= u_clamp;
         end else begin
            res_lin_ff <= u_clamp;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if ((state_ff == pdpf_pkg::ST_FINISH) && (!rsp_tvalid_ff || rsp_tready)) begin
         rsp_tdata_ff <= {t_py_ff, t_px_ff, res_ang_ff, res_lin_ff};
         rsp_tuser_ff <= res_status_ff;
      end
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if ((state_ff == pdpf_pkg::ST_FINISH) && (!rsp_tvalid_ff || rsp_tready)) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      path_len_ff <= LW'(PATH_DEPTH))
      else $error("path length beyond depth");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_goal_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pdpf_pkg::ST_GOAL_WAIT) && b_vld_ff && pipe_hit |=> path_len_ff == '0)
      else $error("goal reached without clearing the path");

endmodule

/* sv/pdpf_path_mem.sv */
// Path point memory: one write port, one read port with registered data.
module pdpf_path_mem #(
   parameter int DEPTH = pdpf_pkg::PATH_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [63:0]              wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [63:0]              rd_data
);

   logic [63:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

/* sv/pdpf_divider.sv */
// Restoring unsigned divider that produces one quotient bit per cycle.
module pdpf_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  pdpf_pkg::div_req_type req,
   output pdpf_pkg::div_rsp_type rsp
);

   localparam int NW = pdpf_pkg::DIV_NUM_W;
   localparam int DW = pdpf_pkg::DIV_DEN_W;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;

   always_comb begin
      trial   = {rem_ff, quo_ff[NW-1]};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start && !busy_ff) begin
         quo_in  = req.num;
         rem_in  = '0;
         den_in  = req.den;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DW'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule
